/* hdl/brcc_pkg.sv */
// ----------------------------------------------------------------------------
// brcc_pkg
// Types, constants and the charge target table of the rest-charge calibrator.
// ----------------------------------------------------------------------------
package brcc_pkg;

  localparam int TABLE_ENTRIES      = 16;
  localparam int CAPACITY_AMP_HOURS = 280;

  localparam int unsigned PIVOT_MV          = 3299;
  localparam int unsigned INFLEXION_FACTOR  = 57;
  localparam int          REST_LIMIT_MA     = -100;
  localparam logic [31:0] ZERO_PERIOD_MS    = 32'd3600000;
  localparam logic [31:0] CALIB_PERIOD_MS   = 32'd1000;
  localparam logic [15:0] MS_PER_MINUTE     = 16'd60000;
  localparam int          MAX_CHARGE_STEP   = 1000;

  // cell voltage window covered by the table
  localparam int unsigned CELL_LO = PIVOT_MV - (TABLE_ENTRIES - 1);
  localparam int unsigned CELL_HI = PIVOT_MV + (TABLE_ENTRIES - 1);

  localparam int IDX_W       = $clog2(2 * TABLE_ENTRIES - 1);
  localparam int TABLE_DEPTH = 2 ** IDX_W;

  // register map
  localparam int          APB_ADDR_W   = 3;
  localparam logic [0:0]  REG_SETTLE   = 1'b0;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [31:0]        count_mas;
    logic [14:0]        battery_mv;
    logic signed [15:0] offset_ma;
    logic signed [23:0] current_ma;
    logic               output_off;
    logic [31:0]        now_ms;
  } brcc_item_t;

  typedef struct packed {
    logic               voltage_out_of_range;
    logic               calibration_ran;
    logic               at_rest;
    logic signed [10:0] charge_step;
    logic signed [1:0]  offset_step;
  } brcc_result_t;

  typedef logic [TABLE_DEPTH-1:0][31:0] brcc_target_arr_t;

  // charge target in mAs for each cell voltage offset from the inflexion point
  function automatic brcc_target_arr_t build_targets();
    brcc_target_arr_t arr;
    longint base;
    longint d;
    longint ad;
    longint mult;
    longint ent;
    base = longint'(INFLEXION_FACTOR) * 36 * CAPACITY_AMP_HOURS;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      d  = longint'(i) - (TABLE_ENTRIES - 1);
      ad = (d < 0) ? -d : d;
      if (ad > TABLE_ENTRIES - 1) begin
        arr[i] = 32'(base * 1000);
      end else begin
        mult = (ad <= 10) ? ad : (10 + 2 * (ad - 10));
        ent  = mult * CAPACITY_AMP_HOURS * 36 / 10;
        arr[i] = (d < 0) ? 32'((base - ent) * 1000) : 32'((base + ent) * 1000);
      end
    end
    return arr;
  endfunction

  localparam brcc_target_arr_t TARGET_MAS = build_targets();

endpackage

/* hdl/brcc_cfg.sv */
// ----------------------------------------------------------------------------
// brcc_cfg
// APB register bank: settle time in minutes, kept also as milliseconds.
// ----------------------------------------------------------------------------
module brcc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brcc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [31:0]                     settle_ms_o
);
  import brcc_pkg::*;

  logic [15:0] settle_minutes_q, settle_minutes_d;
  logic [31:0] settle_ms_q, settle_ms_d;
  logic        reg_hit;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SETTLE);
  assign wr_en   = psel && penable && pwrite && reg_hit;

  always_comb begin
    settle_minutes_d = settle_minutes_q;
    settle_ms_d      = settle_ms_q;
    if (wr_en) begin
      settle_minutes_d = pwdata[15:0];
      settle_ms_d      = 32'(pwdata[15:0]) * 32'(MS_PER_MINUTE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_minutes_q <= '0;
      settle_ms_q      <= '0;
    end else begin
      settle_minutes_q <= settle_minutes_d;
      settle_ms_q      <= settle_ms_d;
    end
  end

  assign prdata      = reg_hit ? {16'd0, settle_minutes_q} : 32'd0;
  assign settle_ms_o = settle_ms_q;

endmodule

/* hdl/brcc_core.sv */
// ----------------------------------------------------------------------------
// brcc_core
// Rest detection, hourly offset timer and per-second charge calibration.
// ----------------------------------------------------------------------------
module brcc_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  brcc_pkg::brcc_item_t   item_i,
  input  logic [31:0]            settle_ms_i,
  output brcc_pkg::brcc_result_t result_o
);
  import brcc_pkg::*;

  logic [31:0] rest_start_q, rest_start_d;
  logic [31:0] zero_stamp_q, zero_stamp_d;
  logic [31:0] calib_stamp_q, calib_stamp_d;

  logic               rest;
  logic [31:0]        elapsed;
  logic               zero_en, zero_fire;
  logic               calib_en, calib_fire;
  logic signed [24:0] sum;
  logic [12:0]        cell_mv;
  logic               in_range;
  logic [12:0]        idx_full;
  logic [IDX_W-1:0]   idx;
  logic [31:0]        target;
  logic signed [32:0] diff;
  logic signed [10:0] step;

  assign rest = item_i.output_off && (item_i.current_ma > 24'(REST_LIMIT_MA));

  assign rest_start_d = rest ? rest_start_q : item_i.now_ms;
  assign elapsed      = item_i.now_ms - rest_start_d;

  assign zero_en   = elapsed >= ZERO_PERIOD_MS;
  assign zero_fire = zero_en && ((item_i.now_ms - zero_stamp_q) >= ZERO_PERIOD_MS);
  assign calib_en   = elapsed >= settle_ms_i;
  assign calib_fire = calib_en && ((item_i.now_ms - calib_stamp_q) >= CALIB_PERIOD_MS);

  // a disabled timer sits one period behind so it fires on its first enabled tick
  always_comb begin
    zero_stamp_d = zero_stamp_q;
    if (!zero_en) begin
      zero_stamp_d = item_i.now_ms - ZERO_PERIOD_MS;
    end else if (zero_fire) begin
      zero_stamp_d = zero_stamp_q + ZERO_PERIOD_MS;
    end
    calib_stamp_d = calib_stamp_q;
    if (!calib_en) begin
      calib_stamp_d = item_i.now_ms - CALIB_PERIOD_MS;
    end else if (calib_fire) begin
      calib_stamp_d = calib_stamp_q + CALIB_PERIOD_MS;
    end
  end

  assign sum = 25'(item_i.current_ma) + 25'(item_i.offset_ma);

  assign cell_mv  = item_i.battery_mv[14:2];
  assign in_range = (cell_mv >= 13'(CELL_LO)) && (cell_mv <= 13'(CELL_HI));
  assign idx_full = cell_mv - 13'(CELL_LO);
  assign idx      = idx_full[IDX_W-1:0];
  assign target   = TARGET_MAS[idx];
  assign diff     = $signed({1'b0, target}) - $signed({1'b0, item_i.count_mas});

  always_comb begin
    if (diff > 33'sd1000) begin
      step = 11'(MAX_CHARGE_STEP);
    end else if (diff < -33'sd1000) begin
      step = -11'(MAX_CHARGE_STEP);
    end else begin
      step = diff[10:0];
    end
  end

  always_comb begin
    result_o = '0;
    result_o.at_rest = rest;
    if (zero_fire) begin
      if (sum > 25'sd0) begin
        result_o.offset_step = -2'sd1;
      end else if (sum < 25'sd0) begin
        result_o.offset_step = 2'sd1;
      end
    end
    if (calib_fire) begin
      result_o.calibration_ran      = 1'b1;
      result_o.voltage_out_of_range = !in_range;
      result_o.charge_step          = in_range ? step : 11'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_start_q  <= '0;
      zero_stamp_q  <= '0;
      calib_stamp_q <= '0;
    end else if (advance_i) begin
      rest_start_q  <= rest_start_d;
      zero_stamp_q  <= zero_stamp_d;
      calib_stamp_q <= calib_stamp_d;
    end
  end

endmodule

/* hdl/battery_rest_charge_calibrator.sv */
// ----------------------------------------------------------------------------
// battery_rest_charge_calibrator
// Top level: input register, calibration logic, result register, APB config.
// ----------------------------------------------------------------------------
// One management tick goes in per transfer and exactly one result comes out.
// A tick is captured in the input register, evaluated against the rest and
// timer state, and lands in the result register, so a new tick is taken
// every cycle while results are being drained. The rate is set by the state
// update of the rest timer and the two repeating timers. The user must write
// settle_minutes over APB only while idle; the block does not enforce it.
module battery_rest_charge_calibrator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_ms[31:0], output_off, current_ma[23:0], offset_ma[15:0],
  // battery_mv[14:0], count_mas[31:0]
  input  logic [brcc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // offset_step[1:0], charge_step[10:0], at_rest, calibration_ran,
  // voltage_out_of_range
  output logic [brcc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [brcc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import brcc_pkg::*;

  logic         in_valid_q, in_valid_d;
  brcc_item_t   item_q;
  logic         out_valid_q, out_valid_d;
  brcc_result_t res_q;
  brcc_result_t res_next;
  logic         advance;
  logic [31:0]  settle_ms;

  brcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .settle_ms_o (settle_ms)
  );

  brcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (item_q),
    .settle_ms_i (settle_ms),
    .result_o    (res_next)
  );

  // the held tick moves on when the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= brcc_item_t'(s_axis_tdata);
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

endmodule

/* tb/sv/battery_rest_charge_calibrator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_rest_charge_calibrator_tb
// Self-checking regression for the rest-time charge calibrator.
// ----------------------------------------------------------------------------
// Management ticks are queued by the stimulus process and sent by a stream
// driver. Each accepted tick is run through a cycle-free model of the rest
// timer, the hourly offset trim and the per-second charge calibration. The
// monitor compares every result with the oldest prediction. The settle time
// register is rewritten over APB between phases, with read-back. Both stream
// sides stall at random, and one phase holds the result side off for a while.
module battery_rest_charge_calibrator_tb;
  import brcc_pkg::*;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr         = '0;
  logic [31:0]             pwdata        = '0;
  logic [31:0]             prdata;
  logic                    pready;

  battery_rest_charge_calibrator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state, mirrors the block from reset
  logic [31:0] rest_start   = '0;
  logic [31:0] hour_stamp   = '0;
  logic [31:0] second_stamp = '0;
  logic [15:0] settle_cfg   = '0;

  brcc_item_t   tick_q[$];
  brcc_result_t result_q[$];
  brcc_item_t   tick_on_bus;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  rx_hold_left  = 0;
  int unsigned  mismatch_cnt  = 0;

  // stimulus side view of time and of when the current rest began
  logic [31:0]  gen_ms         = '0;
  logic [31:0]  gen_rest_begin = '0;

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // charge target in mAs for a cell voltage d mV from the inflexion point
  function automatic longint rest_target_mas(input longint d);
    longint ad;
    longint mult;
    longint base;
    longint ent;
    ad   = (d < 0) ? -d : d;
    mult = (ad <= 10) ? ad : 10 + 2 * (ad - 10);
    base = longint'(INFLEXION_FACTOR) * 36 * CAPACITY_AMP_HOURS;
    ent  = mult * CAPACITY_AMP_HOURS * 36 / 10;
    return ((d < 0) ? base - ent : base + ent) * 1000;
  endfunction

  function automatic brcc_result_t calib_predict(input brcc_item_t t);
    brcc_result_t r;
    logic [31:0]  settle_ms;
    logic [31:0]  elapsed;
    logic [31:0]  since;
    longint       cur;
    longint       sum;
    longint       d;
    longint       diff;
    r         = '0;
    cur       = longint'($signed(t.current_ma));
    r.at_rest = t.output_off && (cur > REST_LIMIT_MA);
    settle_ms = {16'd0, settle_cfg} * 32'(MS_PER_MINUTE);
    if (!r.at_rest) begin
      rest_start = t.now_ms;
    end
    elapsed = t.now_ms - rest_start;

    // hourly offset trim
    since = t.now_ms - hour_stamp;
    if (elapsed < ZERO_PERIOD_MS) begin
      hour_stamp = t.now_ms - ZERO_PERIOD_MS;
    end else if (since >= ZERO_PERIOD_MS) begin
      hour_stamp = hour_stamp + ZERO_PERIOD_MS;
      sum = cur + longint'($signed(t.offset_ma));
      if (sum > 0) begin
        r.offset_step = 2'sb11;
      end else if (sum < 0) begin
        r.offset_step = 2'sb01;
      end
    end

    // per-second charge calibration
    since = t.now_ms - second_stamp;
    if (elapsed < settle_ms) begin
      second_stamp = t.now_ms - CALIB_PERIOD_MS;
    end else if (since >= CALIB_PERIOD_MS) begin
      second_stamp = second_stamp + CALIB_PERIOD_MS;
      r.calibration_ran = 1'b1;
      d = longint'(t.battery_mv / 4) - longint'(PIVOT_MV);
      if (d > TABLE_ENTRIES - 1 || d < -(TABLE_ENTRIES - 1)) begin
        r.voltage_out_of_range = 1'b1;
      end else begin
        diff = rest_target_mas(d) - longint'(t.count_mas);
        if (diff > MAX_CHARGE_STEP) begin
          diff = MAX_CHARGE_STEP;
        end else if (diff < -MAX_CHARGE_STEP) begin
          diff = -MAX_CHARGE_STEP;
        end
        r.charge_step = 11'(diff);
      end
    end
    return r;
  endfunction

  function automatic void queue_tick(input logic [31:0] now, input bit off, input int cur,
                                     input int ofs, input int mv, input logic [31:0] count);
    brcc_item_t t;
    t.now_ms     = now;
    t.output_off = off;
    t.current_ma = 24'(cur);
    t.offset_ma  = 16'(ofs);
    t.battery_mv = 15'(mv);
    t.count_mas  = count;
    if (!(off && cur > REST_LIMIT_MA)) begin
      gen_rest_begin = now;
    end
    gen_ms = now;
    tick_q.push_back(t);
  endfunction

  // mostly plausible tick sequences; the rest is noise
  function automatic void queue_random_tick();
    int unsigned pick;
    logic [31:0] now;
    logic [31:0] count;
    logic [31:0] settle_ms;
    bit          off;
    int          cur;
    int          ofs;
    int          mv;
    longint      d;
    if ($urandom_range(99) < 10) begin
      queue_tick($urandom, 1'($urandom), int'($signed(24'($urandom))),
                 int'($signed(16'($urandom))), int'($urandom_range(32767)), $urandom);
      return;
    end
    settle_ms = {16'd0, settle_cfg} * 32'(MS_PER_MINUTE);
    pick = $urandom_range(99);
    if (pick < 70) begin
      now = gen_ms + $urandom_range(1500, 1);
    end else if (pick < 80) begin
      now = gen_ms + CALIB_PERIOD_MS;
    end else if (pick < 88) begin
      now = gen_ms + $urandom_range(4000000);
    end else if (pick < 95) begin
      // land on or next to the hour or settle boundary of the current rest
      now = gen_rest_begin + ($urandom_range(1) ? ZERO_PERIOD_MS : settle_ms)
            + $urandom_range(2) - 1;
    end else begin
      now = $urandom;
    end
    off = ($urandom_range(99) < 95);
    if ($urandom_range(99) < 90) begin
      cur = int'($urandom_range(360)) - 110;
      ofs = ($urandom_range(99) < 70) ? -cur + int'($urandom_range(4)) - 2
                                      : int'($signed(16'($urandom)));
    end else begin
      cur = int'($signed(24'($urandom)));
      ofs = int'($signed(16'($urandom)));
    end
    mv = ($urandom_range(99) < 80) ? int'($urandom_range(13275, 13120))
                                   : int'($urandom_range(32767));
    d  = longint'(mv / 4) - longint'(PIVOT_MV);
    if (d <= TABLE_ENTRIES - 1 && d >= -(TABLE_ENTRIES - 1) && $urandom_range(99) < 80) begin
      count = 32'(rest_target_mas(d) + longint'($urandom_range(4000)) - 2000);
    end else begin
      count = $urandom;
    end
    queue_tick(now, off, cur, ofs, mv, count);
  endfunction

  // one APB transfer to the settle register; reads are checked against the model
  task automatic settle_reg_access(input bit wr, input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_SETTLE, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      settle_cfg = value;
    end else if (prdata[15:0] !== settle_cfg) begin
      note_mismatch($sformatf("settle_minutes read-back: want %0d got %0d",
                              settle_cfg, prdata[15:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // stream driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(calib_predict(tick_on_bus));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_on_bus = tick_q.pop_front();
          s_axis_tdata  <= tick_on_bus;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long result-side hold-off, counted down here
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    brcc_result_t got;
    brcc_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (result_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result transfer %h", m_axis_tdata));
        end else begin
          want = result_q.pop_front();
          if (got.offset_step !== want.offset_step || got.charge_step !== want.charge_step ||
              got.at_rest !== want.at_rest || got.calibration_ran !== want.calibration_ran ||
              got.voltage_out_of_range !== want.voltage_out_of_range) begin
            note_mismatch($sformatf(
              {"result mismatch: want ofs %0d chg %0d rest %0b ran %0b oor %0b, ",
               "got ofs %0d chg %0d rest %0b ran %0b oor %0b"},
              want.offset_step, want.charge_step, want.at_rest, want.calibration_ran,
              want.voltage_out_of_range, got.offset_step, got.charge_step, got.at_rest,
              got.calibration_ran, got.voltage_out_of_range));
          end
        end
      end
      m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("battery_rest_charge_calibrator regression: fail");
    $finish;
  end

  initial begin
    logic [15:0] settle_val;
    longint      t0;
    longint      t10;
    longint      t11;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 84;
    settle_reg_access(1'b0, '0);

    // directed ticks with no settle time
    t0  = rest_target_mas(0);
    t10 = rest_target_mas(10);
    t11 = rest_target_mas(11);
    queue_tick(32'd0, 1'b0, -8388608, -32768, 0, 32'd0);
    queue_tick(32'd1000, 1'b1, -99, 99, 13196, 32'(t0));
    queue_tick(32'd2000, 1'b1, 0, 0, 13136, 32'd0);
    queue_tick(32'd3000, 1'b1, 0, 0, 13259, 32'hFFFF_FFFF);
    queue_tick(32'd4000, 1'b1, 0, 0, 13135, 32'(t0));
    queue_tick(32'd5000, 1'b1, 0, 0, 13260, 32'd0);
    queue_tick(32'd6000, 1'b1, 0, 0, 32767, 32'd0);
    queue_tick(32'd7000, 1'b1, 0, 0, 13236, 32'(t10 - 1));
    queue_tick(32'd8000, 1'b1, 0, 0, 13240, 32'(t11 + 999));
    // current exactly at the rest limit is not rest
    queue_tick(32'd8500, 1'b1, -100, 0, 13196, 32'(t0));
    queue_tick(32'd9500, 1'b1, 8388607, 32767, 13196, 32'(t0 + 1000));
    // hour boundaries of the rest that began at 8500
    queue_tick(32'd3608500, 1'b1, 8388607, 32767, 13196, 32'(t0));
    queue_tick(32'd7208500, 1'b1, -50, 0, 13196, 32'(t0));
    queue_tick(32'd10808500, 1'b1, 5, -5, 13196, 32'(t0));
    queue_tick(32'd10809499, 1'b1, 5, 0, 13196, 32'(t0));
    queue_tick(32'd10809499, 1'b0, 0, 0, 13196, 32'(t0));
    // time wrapping through zero
    queue_tick(32'hFFFF_FFFF, 1'b1, 0, 0, 13196, 32'd0);
    queue_tick(32'h0000_0200, 1'b1, 0, 0, 13196, 32'hFFFF_FFFF);
    queue_tick(32'h0000_0200, 1'b1, -101, 0, 13196, 32'd0);
    queue_tick(32'h7FFF_FFFF, 1'b1, 0, -32768, 32767, 32'h8000_0000);
    queue_tick(32'h8000_0000, 1'b1, 0, 32767, 0, 32'd0);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: settle_val = 16'd1;
        1: settle_val = 16'hFFFF;
        2: settle_val = 16'($urandom_range(90, 2));
        3: settle_val = 16'd0;
        4: settle_val = 16'hFFFF;
        default: settle_val = 16'($urandom_range(65535));
      endcase
      settle_reg_access(1'b1, settle_val);
      settle_reg_access(1'b0, '0);
      for (int n = 0; n < 115; n++) begin
        queue_random_tick();
      end
      if (phase == 4) begin
        // stall the result side so the block backs up onto its input
        @(posedge clk_i);
        rx_hold_left <= 400;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("battery_rest_charge_calibrator regression: pass");
    end else begin
      $display("battery_rest_charge_calibrator regression: fail");
    end
    $finish;
  end

endmodule
